### rtl/bitmap_frame_allocator_assert.svh
// ----------------------------------------------------------------------------
// Frame allocator assertion macros
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
`define BFA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame allocator same-cycle check failed");
`define BFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame allocator next-cycle check failed");
`else
`define BFA_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define BFA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// Frame allocator package
// Shared widths, codes, state encoding and controller/datapath structs.
// ----------------------------------------------------------------------------
package bfa_pkg;

   localparam int ADDR_W      = 32;
   localparam int COUNT_W     = 16;
   localparam int STATUS_W    = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int FRAME_SHIFT = 12;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_ALLOCATED = 2'd0,
      STATUS_NO_MEMORY = 2'd1,
      STATUS_FREED     = 2'd2,
      STATUS_RANGE     = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_ALLOC_WRITE,
      S_FREE_CHECK,
      S_FREE_DIV,
      S_FREE_FIX,
      S_FREE_READ,
      S_FREE_WRITE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic       accept;
      logic       clr_write;
      logic       scan;
      logic       alloc_write;
      logic       free_check;
      logic       free_div;
      logic       free_fix;
      logic       free_read;
      logic       free_write;
      logic       res_load;
      status_type res_status;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic in_range;
      logic hit;
      logic scan_done;
      logic out_free;
   } sts_type;

endpackage

### rtl/bfa_if.sv
// ----------------------------------------------------------------------------
// Frame allocator channels
// Request, response and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bfa_req_if;
   logic                       valid;
   logic                       ready;
   logic                       operation;
   logic [bfa_pkg::ADDR_W-1:0] frame_address_in;

   modport source (output valid, output operation, output frame_address_in, input ready);
   modport sink   (input valid, input operation, input frame_address_in, output ready);
endinterface

interface bfa_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bfa_pkg::ADDR_W-1:0]   frame_address_out;
   logic [bfa_pkg::STATUS_W-1:0] status;

   modport source (output valid, output frame_address_out, output status, input ready);
   modport sink   (input valid, input frame_address_out, input status, output ready);
endinterface

interface bfa_csr_if;
   logic                          valid;
   logic                          ready;
   logic [bfa_pkg::CSR_IDX_W-1:0] index;
   logic [bfa_pkg::ADDR_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/bfa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bfa_ctrl.sv
// ----------------------------------------------------------------------------
// Frame allocator controller
// Sequences map clearing, first-fit scan and free read-modify-write.
// ----------------------------------------------------------------------------
`include "bitmap_frame_allocator_assert.svh"

module bfa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_operation,
   output logic             req_ready,
   output bfa_pkg::cmd_type cmd,
   input  bfa_pkg::sts_type sts
);

   bfa_pkg::state_type state_ff;
   bfa_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfa_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfa_pkg::S_CLEAR: begin
            if (sts.clr_last) state_in = bfa_pkg::S_IDLE;
         end
         bfa_pkg::S_IDLE: begin
            if (req_valid) begin
               case (req_operation)
                  bfa_pkg::OP_ALLOC: state_in = bfa_pkg::S_SCAN;
                  bfa_pkg::OP_FREE:  state_in = bfa_pkg::S_FREE_CHECK;
                  default:           state_in = bfa_pkg::S_IDLE;
               endcase
            end
         end
         bfa_pkg::S_SCAN: begin
            if (sts.hit) begin
               state_in = bfa_pkg::S_ALLOC_WRITE;
            end else if (sts.scan_done) begin
               state_in = bfa_pkg::S_DONE;
            end
         end
         bfa_pkg::S_ALLOC_WRITE: state_in = bfa_pkg::S_DONE;
         bfa_pkg::S_FREE_CHECK:  state_in = bfa_pkg::S_FREE_DIV;
         bfa_pkg::S_FREE_DIV: begin
            state_in = sts.in_range ? bfa_pkg::S_FREE_FIX : bfa_pkg::S_DONE;
         end
         bfa_pkg::S_FREE_FIX:   state_in = bfa_pkg::S_FREE_READ;
         bfa_pkg::S_FREE_READ:  state_in = bfa_pkg::S_FREE_WRITE;
         bfa_pkg::S_FREE_WRITE: state_in = bfa_pkg::S_DONE;
         bfa_pkg::S_DONE: begin
            if (sts.out_free) state_in = bfa_pkg::S_IDLE;
         end
         default: state_in = bfa_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.res_status = bfa_pkg::STATUS_ALLOCATED;
      req_ready      = 1'b0;
      case (state_ff)
         bfa_pkg::S_CLEAR: cmd.clr_write = 1'b1;
         bfa_pkg::S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         bfa_pkg::S_SCAN: begin
            cmd.scan = 1'b1;
            if (!sts.hit && sts.scan_done) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = bfa_pkg::STATUS_NO_MEMORY;
            end
         end
         bfa_pkg::S_ALLOC_WRITE: begin
            cmd.alloc_write = 1'b1;
            cmd.res_load    = 1'b1;
            cmd.res_status  = bfa_pkg::STATUS_ALLOCATED;
         end
         bfa_pkg::S_FREE_CHECK: cmd.free_check = 1'b1;
         bfa_pkg::S_FREE_DIV: begin
            cmd.free_div = 1'b1;
            if (!sts.in_range) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = bfa_pkg::STATUS_RANGE;
            end
         end
         bfa_pkg::S_FREE_FIX:  cmd.free_fix = 1'b1;
         bfa_pkg::S_FREE_READ: cmd.free_read = 1'b1;
         bfa_pkg::S_FREE_WRITE: begin
            cmd.free_write = 1'b1;
            cmd.res_load   = 1'b1;
            cmd.res_status = bfa_pkg::STATUS_FREED;
         end
         bfa_pkg::S_DONE: cmd.load_out = sts.out_free;
         default: cmd = '0;
      endcase
   end

   `BFA_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, cmd.accept, state_ff != bfa_pkg::S_IDLE)
   `BFA_ASSERT_IMPLY(a_load_into_free_slot, clock, reset, cmd.load_out, sts.out_free)
   `BFA_ASSERT_IMPLY(a_no_request_while_clearing, clock, reset, state_ff == bfa_pkg::S_CLEAR, !req_ready)

endmodule

### rtl/bfa_datapath.sv
// ----------------------------------------------------------------------------
// Frame allocator datapath
// Usage map, scan pipeline, address-to-index divide and result registers.
// ----------------------------------------------------------------------------
`include "bitmap_frame_allocator_assert.svh"

module bfa_datapath #(
   parameter int MAX_FRAMES    = 32768,
   parameter int MAP_WORD_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bfa_pkg::cmd_type               cmd,
   output bfa_pkg::sts_type               sts,
   input  logic [bfa_pkg::ADDR_W-1:0]     req_frame_address_in,
   input  logic                           csr_valid,
   input  logic [bfa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bfa_pkg::ADDR_W-1:0]     csr_data,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [bfa_pkg::ADDR_W-1:0]     rsp_frame_address_out,
   output logic [bfa_pkg::STATUS_W-1:0]   rsp_status
);

   localparam int MapWords = (MAX_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int WordAw   = MapWords > 1 ? $clog2(MapWords) : 1;
   localparam int IdxW     = $clog2(MAX_FRAMES);
   localparam int CntW     = $clog2(MAX_FRAMES + MAP_WORD_BITS + 1);
   localparam int BitW     = $clog2(MAP_WORD_BITS);
   localparam int DivShift = IdxW + 7;
   localparam int RecipW   = DivShift - 2;
   localparam int Recip    = (1 << DivShift) / MAP_WORD_BITS;
   localparam int ProdW    = IdxW + RecipW;
   localparam int QwW      = IdxW + 7;
   localparam int AddrW    = bfa_pkg::ADDR_W;
   localparam int IdxFullW = AddrW - bfa_pkg::FRAME_SHIFT;

   logic [bfa_pkg::COUNT_W-1:0] frame_count_ff, frame_count_in;
   logic [AddrW-1:0]            base_address_ff, base_address_in;
   logic [WordAw-1:0]           clr_word_ff, clr_word_in;
   logic [AddrW-1:0]            addr_ff, addr_in;
   logic [IdxW-1:0]             idx_ff, idx_in;
   logic                        in_range_ff, in_range_in;
   logic [ProdW-1:0]            prod_ff, prod_in;
   logic [WordAw-1:0]           free_word_ff, free_word_in;
   logic [BitW-1:0]             free_bit_ff, free_bit_in;
   logic [WordAw-1:0]           rd_word_ff, rd_word_in;
   logic [CntW-1:0]             rd_first_ff, rd_first_in;
   logic                        ev_valid_ff, ev_valid_in;
   logic [WordAw-1:0]           ev_word_ff, ev_word_in;
   logic [CntW-1:0]             ev_first_ff, ev_first_in;
   logic [WordAw-1:0]           hit_word_ff, hit_word_in;
   logic [IdxW-1:0]             hit_index_ff, hit_index_in;
   logic [MAP_WORD_BITS-1:0]    hit_data_ff, hit_data_in;
   logic [AddrW-1:0]            res_addr_ff, res_addr_in;
   bfa_pkg::status_type         res_status_ff, res_status_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [AddrW-1:0]            rsp_addr_ff, rsp_addr_in;
   bfa_pkg::status_type         rsp_status_ff, rsp_status_in;

   logic [CntW-1:0]          act_count;
   logic                     issue;
   logic [CntW-1:0]          avail_lim;
   logic [MAP_WORD_BITS-1:0] avail_mask;
   logic [MAP_WORD_BITS-1:0] avail;
   logic [BitW-1:0]          bit_sel;
   logic                     hit_found;
   logic [AddrW-1:0]         diff;
   logic [IdxFullW-1:0]      idx_full;
   logic [ProdW-1:0]         q_full;
   logic [IdxW-1:0]          q0;
   logic [QwW-1:0]           qw;
   logic [QwW-1:0]           rem_full;
   logic [BitW:0]            rem;
   logic [MAP_WORD_BITS-1:0] rd_data;
   logic                     wr_en;
   logic [WordAw-1:0]        wr_addr;
   logic [MAP_WORD_BITS-1:0] wr_data;
   logic                     rd_en;
   logic [WordAw-1:0]        rd_addr;

   assign act_count = (AddrW'(frame_count_ff) > AddrW'(MAX_FRAMES)) ?
                      CntW'(MAX_FRAMES) : CntW'(frame_count_ff);
   assign issue     = cmd.scan && (rd_first_ff < act_count);
   assign avail_lim = act_count - ev_first_ff;

   always_comb begin
      for (int b = 0; b < MAP_WORD_BITS; b++) begin
         avail_mask[b] = avail_lim > CntW'(b);
      end
   end

   assign avail     = ~rd_data & avail_mask;
   assign hit_found = ev_valid_ff && (|avail);

   always_comb begin
      bit_sel = '0;
      for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
         if (avail[b]) bit_sel = BitW'(b);
      end
   end

   assign diff     = addr_ff - base_address_ff;
   assign idx_full = diff[AddrW-1:bfa_pkg::FRAME_SHIFT];
   assign q_full   = prod_ff >> DivShift;
   assign q0       = q_full[IdxW-1:0];
   assign qw       = QwW'(q0) * QwW'(MAP_WORD_BITS);
   assign rem_full = QwW'(idx_ff) - qw;
   assign rem      = rem_full[BitW:0];

   always_comb begin
      frame_count_in  = frame_count_ff;
      base_address_in = base_address_ff;
      clr_word_in     = clr_word_ff;
      addr_in         = addr_ff;
      idx_in          = idx_ff;
      in_range_in     = in_range_ff;
      prod_in         = prod_ff;
      free_word_in    = free_word_ff;
      free_bit_in     = free_bit_ff;
      rd_word_in      = rd_word_ff;
      rd_first_in     = rd_first_ff;
      ev_valid_in     = issue;
      ev_word_in      = rd_word_ff;
      ev_first_in     = rd_first_ff;
      hit_word_in     = hit_word_ff;
      hit_index_in    = hit_index_ff;
      hit_data_in     = hit_data_ff;
      res_addr_in     = res_addr_ff;
      res_status_in   = res_status_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_addr_in     = rsp_addr_ff;
      rsp_status_in   = rsp_status_ff;

      if (csr_valid) begin
         case (csr_index)
            bfa_pkg::CSR_FRAME_COUNT:  frame_count_in = csr_data[bfa_pkg::COUNT_W-1:0];
            bfa_pkg::CSR_BASE_ADDRESS: base_address_in = csr_data;
            default: base_address_in = base_address_ff;
         endcase
      end
      if (cmd.clr_write) clr_word_in = clr_word_ff + WordAw'(1);
      if (cmd.accept) begin
         addr_in     = req_frame_address_in;
         rd_word_in  = '0;
         rd_first_in = '0;
         ev_valid_in = 1'b0;
      end
      if (issue) begin
         rd_word_in  = rd_word_ff + WordAw'(1);
         rd_first_in = rd_first_ff + CntW'(MAP_WORD_BITS);
      end
      if (cmd.scan && hit_found) begin
         hit_word_in  = ev_word_ff;
         hit_index_in = IdxW'(ev_first_ff + CntW'(bit_sel));
         hit_data_in  = rd_data | (MAP_WORD_BITS'(1) << bit_sel);
      end
      if (cmd.free_check) begin
         idx_in      = idx_full[IdxW-1:0];
         in_range_in = AddrW'(idx_full) < AddrW'(act_count);
      end
      if (cmd.free_div) prod_in = ProdW'(idx_ff) * ProdW'(RecipW'(Recip));
      if (cmd.free_fix) begin
         if (rem >= (BitW + 1)'(MAP_WORD_BITS)) begin
            free_word_in = WordAw'(q0 + IdxW'(1));
            free_bit_in  = BitW'(rem - (BitW + 1)'(MAP_WORD_BITS));
         end else begin
            free_word_in = WordAw'(q0);
            free_bit_in  = BitW'(rem);
         end
      end
      if (cmd.res_load) begin
         res_status_in = cmd.res_status;
         res_addr_in   = '0;
         if (cmd.res_status == bfa_pkg::STATUS_ALLOCATED) begin
            res_addr_in = base_address_ff + (AddrW'(hit_index_ff) << bfa_pkg::FRAME_SHIFT);
         end
      end
      if (cmd.load_out) begin
         rsp_valid_in  = 1'b1;
         rsp_addr_in   = res_addr_ff;
         rsp_status_in = res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff  <= '0;
         base_address_ff <= '0;
         clr_word_ff     <= '0;
         in_range_ff     <= 1'b0;
         ev_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         frame_count_ff  <= frame_count_in;
         base_address_ff <= base_address_in;
         clr_word_ff     <= clr_word_in;
         in_range_ff     <= in_range_in;
         ev_valid_ff     <= ev_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      idx_ff        <= idx_in;
      prod_ff       <= prod_in;
      free_word_ff  <= free_word_in;
      free_bit_ff   <= free_bit_in;
      rd_word_ff    <= rd_word_in;
      rd_first_ff   <= rd_first_in;
      ev_word_ff    <= ev_word_in;
      ev_first_ff   <= ev_first_in;
      hit_word_ff   <= hit_word_in;
      hit_index_ff  <= hit_index_in;
      hit_data_ff   <= hit_data_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign wr_en = cmd.clr_write || cmd.free_write || cmd.alloc_write;

   always_comb begin
      wr_addr = clr_word_ff;
      wr_data = '0;
      if (cmd.free_write) begin
         wr_addr = free_word_ff;
         wr_data = rd_data & ~(MAP_WORD_BITS'(1) << free_bit_ff);
      end else if (cmd.alloc_write) begin
         wr_addr = hit_word_ff;
         wr_data = hit_data_ff;
      end
   end

   assign rd_en   = issue || cmd.free_read;
   assign rd_addr = cmd.free_read ? free_word_ff : rd_word_ff;

   bfa_ram #(
      .WIDTH (MAP_WORD_BITS),
      .DEPTH (MapWords)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign sts.clr_last  = clr_word_ff == WordAw'(MapWords - 1);
   assign sts.in_range  = in_range_ff;
   assign sts.hit       = hit_found;
   assign sts.scan_done = !ev_valid_ff && !(rd_first_ff < act_count);
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_frame_address_out = rsp_addr_ff;
   assign rsp_status            = rsp_status_ff;

   `BFA_ASSERT_IMPLY(a_free_write_in_range, clock, reset, cmd.free_write, in_range_ff)

endmodule

### rtl/bitmap_frame_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap frame allocator
// First-fit page-frame allocator over a one-bit-per-frame usage map.
// ----------------------------------------------------------------------------
// Usage:
//   csr_ch writes frame_count (index 0) or base_address (index 1); it is
//   always ready and takes effect on the next cycle. Write only while idle.
//   req_ch carries one request: allocate, or free the frame at an address.
//   rsp_ch returns one response per request: address and status.
// Operation:
//   Allocate reads the map one word per cycle from the lowest word; a hit
//   is marked used in the map, and if no frame below frame_count is free
//   the result is out of memory. The single map read port sets this rate.
//   Free steps through index compute and range check, reciprocal
//   multiply, remainder fix, map read, map write and response load; an
//   address out of range skips to the response load with a range status.
//   One request is in progress at a time.
// Reset:
//   Configuration and valid registers clear to zero, then the map is cleared
//   one word per cycle; requests wait.
// Stall:
//   The response sits in an output register; the next request is taken
//   while it waits, and its response holds until the slot is taken.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator #(
   parameter int MAX_FRAMES    = 32768,
   parameter int MAP_WORD_BITS = 32
) (
   input logic      clock,
   input logic      reset,
   bfa_req_if.sink  req_ch,
   bfa_rsp_if.source rsp_ch,
   bfa_csr_if.sink  csr_ch
);

   bfa_pkg::cmd_type cmd;
   bfa_pkg::sts_type sts;

   assign csr_ch.ready = 1'b1;

   bfa_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_operation (req_ch.operation),
      .req_ready     (req_ch.ready),
      .cmd           (cmd),
      .sts           (sts)
   );

   bfa_datapath #(
      .MAX_FRAMES    (MAX_FRAMES),
      .MAP_WORD_BITS (MAP_WORD_BITS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .req_frame_address_in  (req_ch.frame_address_in),
      .csr_valid             (csr_ch.valid),
      .csr_index             (csr_ch.index),
      .csr_data              (csr_ch.data),
      .rsp_ready             (rsp_ch.ready),
      .rsp_valid             (rsp_ch.valid),
      .rsp_frame_address_out (rsp_ch.frame_address_out),
      .rsp_status            (rsp_ch.status)
   );

endmodule
